// File: rtl/ole_pkg.sv
// ole_pkg: shared types, request and status codes for the ordered list engine
// no dependencies
`timescale 1ns / 1ps

package ole_pkg;

   localparam int Capacity = 64;
   localparam int AddrWidth = $clog2(Capacity);
   localparam int CountWidth = AddrWidth + 1;

   typedef enum logic [3:0] {
      REQ_INS_HEAD = 4'd0,
      REQ_INS_TAIL = 4'd1,
      REQ_INS_AT   = 4'd2,
      REQ_REM_HEAD = 4'd3,
      REQ_REM_TAIL = 4'd4,
      REQ_REM_AT   = 4'd5,
      REQ_UPDATE   = 4'd6,
      REQ_GET      = 4'd7,
      REQ_CONTAINS = 4'd8,
      REQ_FIRST    = 4'd9,
      REQ_LAST     = 4'd10,
      REQ_MAX      = 4'd11,
      REQ_MIN      = 4'd12,
      REQ_REVERSE  = 4'd13,
      REQ_CLEAR    = 4'd14,
      REQ_NONE     = 4'd15
   } req_code_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_FULL    = 2'd1,
      ST_RANGE   = 2'd2,
      ST_INVALID = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECIDE,
      S_SHUP_RD,
      S_SHUP_WR,
      S_SHDN_RD,
      S_SHDN_WR,
      S_SCAN_RD,
      S_SCAN_CHK,
      S_REV_RD,
      S_REV_WR,
      S_SINGLE_RD,
      S_SINGLE_WAIT,
      S_DONE,
      S_OUT
   } state_type;

   // memory port command from sequencer to store
   typedef struct packed {
      logic                 wr_en;
      logic [AddrWidth-1:0] wr_addr;
      logic [31:0]          wr_data;
      logic [AddrWidth-1:0] rd_addr_a;
      logic [AddrWidth-1:0] rd_addr_b;
   } mem_cmd_type;

endpackage

// File: rtl/ole_store.sv
// ole_store: entry memory, one write port and two registered read ports
// depends on ole_pkg
`timescale 1ns / 1ps

module ole_store (
   input  logic               clock,
   input  ole_pkg::mem_cmd_type cmd,
   output logic [31:0]        rd_data_a,
   output logic [31:0]        rd_data_b
);

   logic [31:0] mem [ole_pkg::Capacity];

   // write and registered reads
   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[cmd.wr_addr] <= cmd.wr_data;
      end
      rd_data_a <= mem[cmd.rd_addr_a];
      rd_data_b <= mem[cmd.rd_addr_b];
   end

endmodule

// File: rtl/ole_seq.sv
// ole_seq: request sequencer walking the store one entry per step
// depends on ole_pkg, drives ole_store through a command struct
`timescale 1ns / 1ps

module ole_seq (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [ole_pkg::CountWidth-1:0]   csr_wdata,
   input  logic                             start,
   input  logic [3:0]                       op_in,
   input  logic [31:0]                      value_in,
   input  logic [6:0]                       position_in,
   output logic                             busy,
   output logic                             done,
   output logic [1:0]                       status,
   output logic [31:0]                      data_out,
   output logic [6:0]                       found_index,
   output logic                             found,
   output logic [ole_pkg::CountWidth-1:0]   count,
   output ole_pkg::mem_cmd_type             cmd,
   input  logic [31:0]                      rd_data_a,
   input  logic [31:0]                      rd_data_b
);

   localparam int AW = ole_pkg::AddrWidth;
   localparam int CW = ole_pkg::CountWidth;

   ole_pkg::state_type state_ff, state_in;
   logic [3:0]    op_ff;
   logic [31:0]   value_ff;
   logic [6:0]    pos_ff;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] limit_ff;
   logic [CW-1:0] idx_ff, idx_in;   // walking index
   logic [CW-1:0] end_ff, end_in;   // bound or upper index
   logic [1:0]    status_ff, status_in;
   logic [31:0]   data_ff, data_in;
   logic [6:0]    fidx_ff, fidx_in;
   logic          found_ff, found_in;
   logic          full;
   logic [CW-1:0] tpos;             // target position of the request
   logic          take;

   assign full = (count_ff >= CW'(ole_pkg::Capacity)) ||
                 ((limit_ff != '0) && (count_ff >= limit_ff));

   // target position
   always_comb begin
      case (ole_pkg::req_code_type'(op_ff))
         ole_pkg::REQ_INS_HEAD, ole_pkg::REQ_REM_HEAD: tpos = '0;
         ole_pkg::REQ_INS_TAIL: tpos = count_ff;
         ole_pkg::REQ_REM_TAIL: tpos = count_ff - CW'(1);
         default: tpos = pos_ff;
      endcase
   end

   // shared compare unit: signed compare for max and min
   always_comb begin
      if (ole_pkg::req_code_type'(op_ff) == ole_pkg::REQ_MAX) begin
         take = $signed(rd_data_a) > $signed(data_ff);
      end else begin
         take = $signed(rd_data_a) < $signed(data_ff);
      end
   end

   // registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ole_pkg::S_IDLE;
         count_ff <= '0;
         limit_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         if (csr_we) begin
            limit_ff <= csr_wdata;
         end
      end
      if (start) begin
         op_ff <= op_in;
         value_ff <= value_in;
         pos_ff <= position_in;
      end
      idx_ff <= idx_in;
      end_ff <= end_in;
      status_ff <= status_in;
      data_ff <= data_in;
      fidx_ff <= fidx_in;
      found_ff <= found_in;
   end

   // next state and datapath
   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      idx_in = idx_ff;
      end_in = end_ff;
      status_in = status_ff;
      data_in = data_ff;
      fidx_in = fidx_ff;
      found_in = found_ff;
      case (state_ff)
         ole_pkg::S_IDLE: begin
            if (start) begin
               state_in = ole_pkg::S_DECIDE;
            end
         end
         ole_pkg::S_DECIDE: begin
            status_in = ole_pkg::ST_OK;
            data_in = '0;
            fidx_in = 7'h7f;
            found_in = 1'b0;
            state_in = ole_pkg::S_DONE;
            case (ole_pkg::req_code_type'(op_ff))
               ole_pkg::REQ_INS_HEAD, ole_pkg::REQ_INS_TAIL, ole_pkg::REQ_INS_AT: begin
                  if (full) begin
                     status_in = ole_pkg::ST_FULL;
                  end else if (tpos > count_ff) begin
                     status_in = ole_pkg::ST_RANGE;
                  end else begin
                     // shift up from tail down to target
                     idx_in = count_ff;
                     end_in = tpos;
                     state_in = ole_pkg::S_SHUP_RD;
                  end
               end
               ole_pkg::REQ_REM_HEAD, ole_pkg::REQ_REM_TAIL, ole_pkg::REQ_REM_AT: begin
                  if (count_ff == '0) begin
                     status_in = ole_pkg::ST_INVALID;
                  end else if (tpos >= count_ff) begin
                     status_in = ole_pkg::ST_RANGE;
                  end else begin
                     idx_in = tpos;
                     state_in = ole_pkg::S_SINGLE_RD;
                  end
               end
               ole_pkg::REQ_UPDATE, ole_pkg::REQ_GET: begin
                  if (count_ff == '0) begin
                     status_in = ole_pkg::ST_INVALID;
                  end else if (tpos >= count_ff) begin
                     status_in = ole_pkg::ST_RANGE;
                  end else begin
                     idx_in = tpos;
                     state_in = ole_pkg::S_SINGLE_RD;
                  end
               end
               ole_pkg::REQ_CONTAINS, ole_pkg::REQ_FIRST, ole_pkg::REQ_LAST,
               ole_pkg::REQ_MAX, ole_pkg::REQ_MIN: begin
                  if (count_ff != '0) begin
                     idx_in = '0;
                     state_in = ole_pkg::S_SCAN_RD;
                  end
               end
               ole_pkg::REQ_REVERSE: begin
                  if (count_ff < CW'(2)) begin
                     status_in = ole_pkg::ST_INVALID;
                  end else begin
                     idx_in = '0;
                     end_in = count_ff - CW'(1);
                     state_in = ole_pkg::S_REV_RD;
                  end
               end
               ole_pkg::REQ_CLEAR: count_in = '0;
               default: status_in = ole_pkg::ST_INVALID;
            endcase
         end
         // insert: move entry idx-1 to idx until idx reaches target
         ole_pkg::S_SHUP_RD: begin
            if (idx_ff == end_ff) begin
               count_in = count_ff + CW'(1);
               state_in = ole_pkg::S_DONE;
            end else begin
               state_in = ole_pkg::S_SHUP_WR;
            end
         end
         ole_pkg::S_SHUP_WR: begin
            idx_in = idx_ff - CW'(1);
            state_in = ole_pkg::S_SHUP_RD;
         end
         // remove: move entry idx+1 to idx up to the tail
         ole_pkg::S_SHDN_RD: begin
            if (idx_ff + CW'(1) >= count_ff) begin
               count_in = count_ff - CW'(1);
               state_in = ole_pkg::S_DONE;
            end else begin
               state_in = ole_pkg::S_SHDN_WR;
            end
         end
         ole_pkg::S_SHDN_WR: begin
            idx_in = idx_ff + CW'(1);
            state_in = ole_pkg::S_SHDN_RD;
         end
         ole_pkg::S_SINGLE_RD: state_in = ole_pkg::S_SINGLE_WAIT;
         ole_pkg::S_SINGLE_WAIT: begin
            case (ole_pkg::req_code_type'(op_ff))
               ole_pkg::REQ_GET: begin
                  data_in = rd_data_a;
                  state_in = ole_pkg::S_DONE;
               end
               ole_pkg::REQ_UPDATE: state_in = ole_pkg::S_DONE;
               default: begin
                  data_in = rd_data_a;
                  state_in = ole_pkg::S_SHDN_RD;
               end
            endcase
         end
         // scan: read one entry, then check it before the next read; max and min go through the compare unit
         ole_pkg::S_SCAN_RD: state_in = ole_pkg::S_SCAN_CHK;
         ole_pkg::S_SCAN_CHK: begin
            case (ole_pkg::req_code_type'(op_ff))
               ole_pkg::REQ_MAX, ole_pkg::REQ_MIN: begin
                  if (idx_ff == '0 || take) begin
                     data_in = rd_data_a;
                  end
               end
               default: begin
                  if (rd_data_a == value_ff) begin
                     found_in = 1'b1;
                     if (ole_pkg::req_code_type'(op_ff) == ole_pkg::REQ_LAST ||
                         fidx_ff == 7'h7f) begin
                        fidx_in = 7'(idx_ff);
                     end
                  end
               end
            endcase
            idx_in = idx_ff + CW'(1);
            if (idx_ff + CW'(1) >= count_ff) begin
               state_in = ole_pkg::S_DONE;
            end else begin
               state_in = ole_pkg::S_SCAN_RD;
            end
         end
         // reverse: swap the pair idx and end
         ole_pkg::S_REV_RD: begin
            if (idx_ff >= end_ff) begin
               state_in = ole_pkg::S_DONE;
            end else begin
               state_in = ole_pkg::S_REV_WR;
            end
         end
         ole_pkg::S_REV_WR: begin
            idx_in = idx_ff + CW'(1);
            end_in = end_ff - CW'(1);
            state_in = ole_pkg::S_REV_RD;
         end
         ole_pkg::S_DONE: begin
            case (ole_pkg::req_code_type'(op_ff))
               ole_pkg::REQ_CONTAINS: fidx_in = 7'h7f;
               ole_pkg::REQ_FIRST, ole_pkg::REQ_LAST: found_in = 1'b0;
               default: ;
            endcase
            if (status_ff != ole_pkg::ST_OK) begin
               data_in = '0;
            end
            state_in = ole_pkg::S_OUT;
         end
         ole_pkg::S_OUT: state_in = ole_pkg::S_IDLE;
         default: state_in = ole_pkg::S_IDLE;
      endcase
   end

   // memory command: reads issue in *_RD states, data used in the next state
   always_comb begin
      cmd = '0;
      case (state_ff)
         ole_pkg::S_SHUP_RD: cmd.rd_addr_a = AW'(idx_ff - CW'(1));
         ole_pkg::S_SHUP_WR: begin
            cmd.wr_en = 1'b1;
            cmd.wr_addr = AW'(idx_ff);
            cmd.wr_data = rd_data_a;
         end
         ole_pkg::S_SHDN_RD: cmd.rd_addr_a = AW'(idx_ff + CW'(1));
         ole_pkg::S_SHDN_WR: begin
            cmd.wr_en = 1'b1;
            cmd.wr_addr = AW'(idx_ff);
            cmd.wr_data = rd_data_a;
         end
         ole_pkg::S_SINGLE_RD: cmd.rd_addr_a = AW'(idx_ff);
         ole_pkg::S_SCAN_RD: cmd.rd_addr_a = AW'(idx_ff);
         ole_pkg::S_REV_RD: begin
            cmd.rd_addr_a = AW'(idx_ff);
            cmd.rd_addr_b = AW'(end_ff);
         end
         ole_pkg::S_REV_WR: begin
            // end entry written here, idx entry in the next REV_RD;
            // port b re-reads the old end entry for that second write
            cmd.wr_en = 1'b1;
            cmd.wr_addr = AW'(end_ff);
            cmd.wr_data = rd_data_a;
            cmd.rd_addr_b = AW'(end_ff);
         end
         default: ;
      endcase
      // insert target write happens when the shift reaches the target
      if (state_ff == ole_pkg::S_SHUP_RD && idx_ff == end_ff) begin
         cmd.wr_en = 1'b1;
         cmd.wr_addr = AW'(idx_ff);
         cmd.wr_data = value_ff;
      end
      if (state_ff == ole_pkg::S_SINGLE_WAIT &&
          ole_pkg::req_code_type'(op_ff) == ole_pkg::REQ_UPDATE) begin
         cmd.wr_en = 1'b1;
         cmd.wr_addr = AW'(idx_ff);
         cmd.wr_data = value_ff;
      end
      // second half of the swap: port b holds the old end entry read in REV_WR
      if (state_ff == ole_pkg::S_REV_RD && idx_ff > '0 && idx_ff <= end_ff + CW'(1)
          && idx_ff != '0) begin
         cmd.wr_en = 1'b1;
         cmd.wr_addr = AW'(idx_ff - CW'(1));
         cmd.wr_data = rd_data_b;
      end
   end

   // outputs
   always_comb begin
      busy = (state_ff != ole_pkg::S_IDLE);
      done = (state_ff == ole_pkg::S_OUT);
      status = status_ff;
      data_out = data_ff;
      found_index = fidx_ff;
      found = found_ff;
      count = count_ff;
   end

endmodule

// File: rtl/ordered_list_engine_unit.sv
// ordered_list_engine_unit: top level, stream ports around sequencer and store
// depends on ole_pkg, ole_seq, ole_store
`timescale 1ns / 1ps

//  channel | dir | contents
//  req_    | in  | tdata: req_type[3:0], value[35:4], position[42:36]
//  rsp_    | out | tdata: status[1:0], data_out[33:2], found_index[40:34],
//          |     |        found[41], count[48:42]
//  csr_    | in  | entry_limit, written when csr_we is high
//  the time per word grows with each entry scanned or shifted
//  (search, max, min, insert, remove) or pair swapped (reverse)
//  the single port pair of the entry store sets that pace
//  reset is synchronous; it clears the count and limit, not the store
//  a result stays in an output register until rsp_tready; the next word is
//  taken once the result register is free

module ordered_list_engine_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // req_type, value, position
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // status, data_out, found_index, found, count
   input  logic        csr_we,
   input  logic [6:0]  csr_wdata
);

   ole_pkg::mem_cmd_type cmd;
   logic [31:0] rd_a, rd_b;
   logic        busy, done, found;
   logic [1:0]  status;
   logic [31:0] data_out;
   logic [6:0]  fidx;
   logic [6:0]  count;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [55:0] rsp_data_ff, rsp_data_in;
   logic        start;

   assign req_tready = !busy && !rsp_valid_ff;
   assign start = req_tvalid && req_tready;

   ole_seq u_seq (
      .clock(clock), .reset(reset), .csr_we(csr_we), .csr_wdata(csr_wdata),
      .start(start), .op_in(req_tdata[3:0]), .value_in(req_tdata[35:4]),
      .position_in(req_tdata[42:36]), .busy(busy), .done(done),
      .status(status), .data_out(data_out), .found_index(fidx), .found(found),
      .count(count), .cmd(cmd), .rd_data_a(rd_a), .rd_data_b(rd_b)
   );

   ole_store u_store (.clock(clock), .cmd(cmd), .rd_data_a(rd_a), .rd_data_b(rd_b));

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in = rsp_data_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (done) begin
         rsp_valid_in = 1'b1;
         rsp_data_in = {7'd0, count, found, fidx, data_out, status};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;

endmodule

// File: rtl/ole_checker.sv
// ole_checker: port-level assertions for the ordered list engine
// bound to ordered_list_engine_unit
`timescale 1ns / 1ps

module ole_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [55:0] rsp_tdata
);

   // no new word while a result waits
   a_no_accept: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready) else $error("accepted with result pending");

   // a stalled result holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result dropped");

   // accepted word is busy next cycle
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready) else $error("ready after accept");

   // count never exceeds capacity
   a_count: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[48:42] <= 7'd64) else $error("count overflow");

endmodule

bind ordered_list_engine_unit ole_checker u_chk (
   .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
);

// File: dv/tb.sv
// tb: self-checking bench for ordered_list_engine_unit, directed table then random traffic
// depends on ole_pkg and the rtl top level
`timescale 1ns / 1ps

module tb;

   typedef struct packed {
      logic [6:0]  count;
      logic        found;
      logic [6:0]  found_index;
      logic [31:0] data_out;
      logic [1:0]  status;
   } list_rsp_type;

   typedef struct {
      ole_pkg::req_code_type code;
      logic [31:0]  value;
      logic [6:0]   position;
      logic         typed;
      list_rsp_type want;
   } stim_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [55:0] rsp_tdata;
   logic        csr_we = 1'b0;
   logic [6:0]  csr_wdata = '0;

   // shadow copy of the list
   logic [31:0] shadow_store [ole_pkg::Capacity];
   int unsigned shadow_count;
   int unsigned shadow_limit;

   list_rsp_type pending_rsp [$];
   list_rsp_type typed_rsp [$];
   bit           typed_flag [$];
   int errors = 0;
   int words_sent = 0;
   int words_seen = 0;
   int idle_cycles = 0;
   bit hold_rsp = 1'b0;
   bit drain_on = 1'b0;

   ordered_list_engine_unit dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic bit list_full();
      return shadow_count >= ole_pkg::Capacity ||
             (shadow_limit != 0 && shadow_count >= shadow_limit);
   endfunction

   // predicted response for one request, updating the shadow list
   function automatic list_rsp_type list_apply(ole_pkg::req_code_type code, logic [31:0] v,
                                               logic [6:0] pos);
      list_rsp_type r;
      int unsigned p;
      logic [31:0] t;
      r = '{status: ole_pkg::ST_OK, data_out: '0, found_index: 7'h7f, found: 1'b0,
            count: '0};
      case (code)
         ole_pkg::REQ_INS_HEAD, ole_pkg::REQ_INS_TAIL, ole_pkg::REQ_INS_AT: begin
            p = code == ole_pkg::REQ_INS_HEAD ? 0 :
                code == ole_pkg::REQ_INS_TAIL ? shadow_count : pos;
            if (list_full()) r.status = ole_pkg::ST_FULL;
            else if (p > shadow_count) r.status = ole_pkg::ST_RANGE;
            else begin
               for (int i = shadow_count; i > p; i--) shadow_store[i] = shadow_store[i-1];
               shadow_store[p] = v;
               shadow_count++;
            end
         end
         ole_pkg::REQ_REM_HEAD, ole_pkg::REQ_REM_TAIL, ole_pkg::REQ_REM_AT: begin
            p = code == ole_pkg::REQ_REM_HEAD ? 0 :
                code == ole_pkg::REQ_REM_TAIL ? shadow_count - 1 : pos;
            if (shadow_count == 0) r.status = ole_pkg::ST_INVALID;
            else if (p >= shadow_count) r.status = ole_pkg::ST_RANGE;
            else begin
               r.data_out = shadow_store[p];
               for (int i = p; i < shadow_count - 1; i++) shadow_store[i] = shadow_store[i+1];
               shadow_count--;
            end
         end
         ole_pkg::REQ_UPDATE, ole_pkg::REQ_GET: begin
            if (shadow_count == 0) r.status = ole_pkg::ST_INVALID;
            else if (pos >= shadow_count) r.status = ole_pkg::ST_RANGE;
            else if (code == ole_pkg::REQ_UPDATE) shadow_store[pos] = v;
            else r.data_out = shadow_store[pos];
         end
         ole_pkg::REQ_CONTAINS, ole_pkg::REQ_FIRST, ole_pkg::REQ_LAST: begin
            for (int i = 0; i < shadow_count; i++)
               if (shadow_store[i] == v) begin
                  r.found = 1'b1;
                  if (code == ole_pkg::REQ_LAST || r.found_index == 7'h7f)
                     r.found_index = i[6:0];
               end
            if (code == ole_pkg::REQ_CONTAINS) r.found_index = 7'h7f;
            else r.found = 1'b0;
         end
         ole_pkg::REQ_MAX, ole_pkg::REQ_MIN: begin
            if (shadow_count > 0) begin
               r.data_out = shadow_store[0];
               for (int i = 1; i < shadow_count; i++)
                  if (code == ole_pkg::REQ_MAX ?
                      $signed(shadow_store[i]) > $signed(r.data_out) :
                      $signed(shadow_store[i]) < $signed(r.data_out))
                     r.data_out = shadow_store[i];
            end
         end
         ole_pkg::REQ_REVERSE: begin
            if (shadow_count < 2) r.status = ole_pkg::ST_INVALID;
            else for (int i = 0; i < shadow_count / 2; i++) begin
               t = shadow_store[i];
               shadow_store[i] = shadow_store[shadow_count-1-i];
               shadow_store[shadow_count-1-i] = t;
            end
         end
         ole_pkg::REQ_CLEAR: shadow_count = 0;
         default: r.status = ole_pkg::ST_INVALID;
      endcase
      if (r.status != ole_pkg::ST_OK) r.data_out = '0;
      r.count = shadow_count[6:0];
      return r;
   endfunction

   // offer one word, wait for acceptance; valid stays high when no gap follows
   task automatic send_word(ole_pkg::req_code_type code, logic [31:0] v, logic [6:0] pos,
                            bit typed, list_rsp_type want, bit no_gap);
      list_rsp_type r;
      int gap;
      gap = no_gap ? 0 : $urandom_range(0, 14);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      r = list_apply(code, v, pos);
      pending_rsp.push_back(r);
      typed_rsp.push_back(want);
      typed_flag.push_back(typed);
      req_tdata <= {5'd0, pos, v, code};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      words_sent++;
      @(negedge clock);
   endtask

   // random word, mostly valid positions, mixed value pool to get hits
   task automatic send_random(bit no_gap);
      ole_pkg::req_code_type code;
      logic [31:0] v;
      logic [6:0] pos;
      code = ole_pkg::req_code_type'($urandom_range(0, 15));
      if (code == ole_pkg::REQ_CLEAR && $urandom_range(0, 3) != 0) code = ole_pkg::REQ_INS_TAIL;
      if (code == ole_pkg::REQ_REVERSE && $urandom_range(0, 1)) code = ole_pkg::REQ_INS_AT;
      v = $urandom_range(0, 2) == 0 ? $urandom : $urandom_range(0, 7) - 4;
      pos = $urandom_range(0, 7) == 0 ? 7'($urandom_range(0, 127))
                                      : 7'($urandom_range(0, shadow_count));
      send_word(code, v, pos, 1'b0, '0, no_gap);
   endtask

   // wait for an idle block, then write the limit
   task automatic write_limit(logic [6:0] lim);
      req_tvalid <= 1'b0;
      while (pending_rsp.size() != 0) @(negedge clock);
      repeat (150) @(negedge clock);
      csr_wdata <= lim;
      csr_we <= 1'b1;
      @(negedge clock);
      csr_we <= 1'b0;
      shadow_limit = lim;
   endtask

   // response side: random stalls, or a long hold-off counted here on request
   initial begin
      int gap;
      @(negedge clock);
      while (1) begin
         gap = drain_on ? 0 : $urandom_range(0, 14);
         if ($urandom_range(0, 5) == 0) gap = 0;
         if (gap != 0 || hold_rsp) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(negedge clock);
            if (hold_rsp) begin
               repeat (400) @(negedge clock);
               hold_rsp = 1'b0;
            end
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         @(negedge clock);
      end
   end

   // response checker
   always @(posedge clock) begin
      list_rsp_type got, exp, typ;
      bit tf;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[48:0];
         words_seen++;
         if (pending_rsp.size() == 0) begin
            $display("%0t: unexpected word %h", $time, got);
            errors++;
         end else begin
            exp = pending_rsp.pop_front();
            typ = typed_rsp.pop_front();
            tf = typed_flag.pop_front();
            if (tf && typ != exp) begin
               $display("%0t: table row disagrees, expected %h predicted %h", $time, typ, exp);
               errors++;
            end
            if (got.status != exp.status || got.data_out != exp.data_out ||
                got.found_index != exp.found_index || got.found != exp.found ||
                got.count != exp.count) begin
               $display({"%0t: mismatch, expected st=%0d data=%h idx=%h fnd=%0d cnt=%0d,",
                         " actual st=%0d data=%h idx=%h fnd=%0d cnt=%0d"},
                        $time, exp.status, exp.data_out, exp.found_index, exp.found,
                        exp.count, got.status, got.data_out, got.found_index, got.found,
                        got.count);
               errors++;
            end
         end
      end
   end

   // watchdog on cycles with no handshake
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 5000) begin
         $display("tb: done, errors");
         $finish;
      end
   end

   // directed table: rows with a typed response, the rest predicted
   stim_row_type dir_rows [$];
   function automatic list_rsp_type rsp(int st, logic [31:0] d, logic [6:0] idx, bit f,
                                        int cnt);
      return '{status: st[1:0], data_out: d, found_index: idx, found: f, count: cnt[6:0]};
   endfunction
   task automatic add_row(ole_pkg::req_code_type c, logic [31:0] v, logic [6:0] p, bit t,
                          list_rsp_type w);
      dir_rows.push_back('{code: c, value: v, position: p, typed: t, want: w});
   endtask

   initial begin
      shadow_count = 0;
      shadow_limit = 0;
      // empty list cases
      add_row(ole_pkg::REQ_REM_HEAD, 0, 0, 1, rsp(ole_pkg::ST_INVALID, 0, 7'h7f, 0, 0));
      add_row(ole_pkg::REQ_REM_TAIL, 0, 0, 1, rsp(ole_pkg::ST_INVALID, 0, 7'h7f, 0, 0));
      add_row(ole_pkg::REQ_REM_AT, 0, 5, 1, rsp(ole_pkg::ST_INVALID, 0, 7'h7f, 0, 0));
      add_row(ole_pkg::REQ_UPDATE, 1, 0, 1, rsp(ole_pkg::ST_INVALID, 0, 7'h7f, 0, 0));
      add_row(ole_pkg::REQ_GET, 0, 0, 1, rsp(ole_pkg::ST_INVALID, 0, 7'h7f, 0, 0));
      add_row(ole_pkg::REQ_MAX, 0, 0, 1, rsp(ole_pkg::ST_OK, 0, 7'h7f, 0, 0));
      add_row(ole_pkg::REQ_MIN, 0, 0, 1, rsp(ole_pkg::ST_OK, 0, 7'h7f, 0, 0));
      add_row(ole_pkg::REQ_FIRST, 0, 0, 1, rsp(ole_pkg::ST_OK, 0, 7'h7f, 0, 0));
      add_row(ole_pkg::REQ_CONTAINS, 0, 0, 1, rsp(ole_pkg::ST_OK, 0, 7'h7f, 0, 0));
      add_row(ole_pkg::REQ_REVERSE, 0, 0, 1, rsp(ole_pkg::ST_INVALID, 0, 7'h7f, 0, 0));
      add_row(ole_pkg::REQ_NONE, 32'hffffffff, 7'h7f, 1,
              rsp(ole_pkg::ST_INVALID, 0, 7'h7f, 0, 0));
      // extremes of the value field
      add_row(ole_pkg::REQ_INS_HEAD, 32'h7fffffff, 0, 1, rsp(ole_pkg::ST_OK, 0, 7'h7f, 0, 1));
      add_row(ole_pkg::REQ_INS_TAIL, 32'h80000000, 0, 1, rsp(ole_pkg::ST_OK, 0, 7'h7f, 0, 2));
      add_row(ole_pkg::REQ_INS_AT, 32'd5, 7'd127, 1, rsp(ole_pkg::ST_RANGE, 0, 7'h7f, 0, 2));
      add_row(ole_pkg::REQ_INS_AT, 32'hffffffff, 2, 0, '0);
      add_row(ole_pkg::REQ_MAX, 0, 0, 1, rsp(ole_pkg::ST_OK, 32'h7fffffff, 7'h7f, 0, 3));
      add_row(ole_pkg::REQ_MIN, 0, 0, 1, rsp(ole_pkg::ST_OK, 32'h80000000, 7'h7f, 0, 3));
      add_row(ole_pkg::REQ_INS_AT, 32'hffffffff, 1, 0, '0);
      add_row(ole_pkg::REQ_FIRST, 32'hffffffff, 0, 0, '0);
      add_row(ole_pkg::REQ_LAST, 32'hffffffff, 0, 0, '0);
      add_row(ole_pkg::REQ_GET, 0, 7'd127, 1, rsp(ole_pkg::ST_RANGE, 0, 7'h7f, 0, 4));
      add_row(ole_pkg::REQ_UPDATE, 32'h12345678, 3, 0, '0);
      add_row(ole_pkg::REQ_REVERSE, 0, 0, 0, '0);
      add_row(ole_pkg::REQ_REM_AT, 0, 1, 0, '0);
      add_row(ole_pkg::REQ_CLEAR, 0, 0, 1, rsp(ole_pkg::ST_OK, 0, 7'h7f, 0, 0));

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      foreach (dir_rows[i])
         send_word(dir_rows[i].code, dir_rows[i].value, dir_rows[i].position,
                   dir_rows[i].typed, dir_rows[i].want, 1'b0);

      // random phases across limit settings, extremes included
      for (int ph = 0; ph < 7; ph++) begin
         case (ph)
            0: write_limit(7'd0);
            1: write_limit(7'd1);
            2: write_limit(7'd64);
            3: write_limit(7'd127);
            4: write_limit(7'($urandom_range(2, 12)));
            default: write_limit(7'($urandom_range(0, 70)));
         endcase
         if (ph == 3) begin
            // fill to capacity, then the response side holds off on its own
            for (int k = 0; k < 70; k++)
               send_word(ole_pkg::REQ_INS_TAIL, $urandom, 0, 0, '0, 1'b1);
            hold_rsp = 1'b1;
            for (int k = 0; k < 6; k++) send_random(1'b1);
            send_word(ole_pkg::REQ_LAST, shadow_store[0], 0, 0, '0, 1'b0);
            send_word(ole_pkg::REQ_CLEAR, 0, 0, 0, '0, 1'b0);
         end
         for (int k = 0; k < 130; k++) send_random($urandom_range(0, 9) == 0);
      end

      req_tvalid <= 1'b0;
      drain_on = 1'b1;
      while (pending_rsp.size() != 0) @(negedge clock);
      repeat (200) @(negedge clock);
      $display("tb: %0d requests sent, %0d responses checked over several limit settings",
               words_sent, words_seen);
      if (errors == 0)
         $display("tb: done, clean");
      else
         $display("tb: done, errors");
      $finish;
   end

endmodule

// File: files.f
rtl/ole_pkg.sv
rtl/ole_store.sv
rtl/ole_seq.sv
rtl/ordered_list_engine_unit.sv
rtl/ole_checker.sv
dv/tb.sv
